### rtl/vsr_pkg.sv
// Shared types and constants of the voxel surface relabel block.
`timescale 1ns / 1ps
`default_nettype none
package vsr_pkg;

  localparam int MAX_DIM    = 32;
  localparam int VALUE_BITS = 32;
  localparam int DIM_W      = $clog2(MAX_DIM + 1);
  localparam int AXIS_W     = $clog2(MAX_DIM);
  localparam int ADDR_W     = 3 * AXIS_W;
  localparam int DEPTH      = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int STRIDE_W   = 2 * DIM_W;
  localparam int COUNT_W    = 16;
  localparam int TOL_W      = 31;
  localparam int PAD_W      = 5;
  localparam int CFG_W      = 32;
  localparam int NB_W       = 3;

  localparam logic [NB_W-1:0] NB_LAST = NB_W'(5);

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_RUN   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    CFG_OLD_VALUE = 3'd0,
    CFG_ADJ_VALUE = 3'd1,
    CFG_NEW_VALUE = 3'd2,
    CFG_TOLERANCE = 3'd3,
    CFG_PAD_WIDTH = 3'd4,
    CFG_SIZE_X    = 3'd5,
    CFG_SIZE_Y    = 3'd6,
    CFG_SIZE_Z    = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_DATA, ST_INIT1, ST_INIT2, ST_INIT3, ST_CTR_RD, ST_CTR_CHK,
    ST_NB_RD, ST_NB_CHK, ST_WRITE, ST_ADVANCE, ST_REPORT
  } state_t;

  typedef struct packed {
    logic rd_ext;
    logic wr_ext;
    logic init1;
    logic init2;
    logic init3;
    logic ctr_rd;
    logic nb_rd;
    logic nb_clr;
    logic nb_inc;
    logic wr_new;
    logic advance;
    logic load_read;
    logic load_report;
  } ctl_t;

  typedef struct packed {
    logic box_empty;
    logic near_old;
    logic near_adj;
    logic nb_valid;
    logic nb_last;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

### rtl/vsr_if.sv
// Request and response channel interfaces of the voxel surface relabel block.
`timescale 1ns / 1ps
`default_nettype none
interface vsr_req_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      command;
  logic [vsr_pkg::ADDR_W-1:0]      voxel_index;
  logic signed [vsr_pkg::VALUE_BITS-1:0] voxel_value;
  modport source (output valid, command, voxel_index, voxel_value, input ready);
  modport sink (input valid, command, voxel_index, voxel_value, output ready);
endinterface

interface vsr_rsp_if;
  logic                            valid;
  logic                            ready;
  logic signed [vsr_pkg::VALUE_BITS-1:0] read_value;
  logic [vsr_pkg::COUNT_W-1:0]     changed_count;
  logic                            is_run_report;
  modport source (output valid, read_value, changed_count, is_run_report, input ready);
  modport sink (input valid, read_value, changed_count, is_run_report, output ready);
endinterface
`default_nettype wire

### rtl/vsr_ctrl.sv
// Controller state machine of the voxel surface relabel block.
`timescale 1ns / 1ps
`default_nettype none
module vsr_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  input  wire logic [1:0]   in_command,
  output logic              in_ready,
  input  wire vsr_pkg::sts_t sts,
  output vsr_pkg::ctl_t     ctl
);
  import vsr_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_command)
            OP_WRITE: ctl.wr_ext = 1'b1;
            OP_READ: begin
              ctl.rd_ext = 1'b1;
              state_next = ST_RD_DATA;
            end
            OP_RUN:   state_next = ST_INIT1;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_RD_DATA: begin
        if (sts.out_free) begin
          ctl.load_read = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_INIT1: begin
        ctl.init1  = 1'b1;
        state_next = sts.box_empty ? ST_REPORT : ST_INIT2;
      end
      ST_INIT2: begin
        ctl.init2  = 1'b1;
        state_next = ST_INIT3;
      end
      ST_INIT3: begin
        ctl.init3  = 1'b1;
        state_next = ST_CTR_RD;
      end
      ST_CTR_RD: begin
        ctl.ctr_rd = 1'b1;
        state_next = ST_CTR_CHK;
      end
      ST_CTR_CHK: begin
        if (sts.near_old) begin
          ctl.nb_clr = 1'b1;
          state_next = ST_NB_RD;
        end else begin
          state_next = ST_ADVANCE;
        end
      end
      ST_NB_RD: begin
        if (sts.nb_valid) begin
          ctl.nb_rd  = 1'b1;
          state_next = ST_NB_CHK;
        end else if (sts.nb_last) begin
          state_next = ST_ADVANCE;
        end else begin
          ctl.nb_inc = 1'b1;
        end
      end
      ST_NB_CHK: begin
        if (sts.near_adj) begin
          state_next = ST_WRITE;
        end else if (sts.nb_last) begin
          state_next = ST_ADVANCE;
        end else begin
          ctl.nb_inc = 1'b1;
          state_next = ST_NB_RD;
        end
      end
      ST_WRITE: begin
        ctl.wr_new = 1'b1;
        state_next = ST_ADVANCE;
      end
      ST_ADVANCE: begin
        ctl.advance = 1'b1;
        state_next  = sts.scan_done ? ST_REPORT : ST_CTR_RD;
      end
      ST_REPORT: begin
        if (sts.out_free) begin
          ctl.load_report = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### rtl/vsr_dpath.sv
// Datapath of the voxel surface relabel block: registers, voxel memory, scan counters.
`timescale 1ns / 1ps
`default_nettype none
module vsr_dpath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [2:0]                          cfg_index,
  input  wire logic [vsr_pkg::CFG_W-1:0]           cfg_wdata,
  input  wire logic [vsr_pkg::ADDR_W-1:0]          in_index,
  input  wire logic signed [vsr_pkg::VALUE_BITS-1:0] in_value,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output logic signed [vsr_pkg::VALUE_BITS-1:0]    out_read_value,
  output logic [vsr_pkg::COUNT_W-1:0]              out_changed_count,
  output logic                                     out_is_run,
  input  wire vsr_pkg::ctl_t                       ctl,
  output vsr_pkg::sts_t                            sts
);
  import vsr_pkg::*;

  logic signed [VALUE_BITS-1:0] old_value, adjacent_value, new_value;
  logic [TOL_W-1:0]             tolerance;
  logic [PAD_W-1:0]             pad_width;
  logic [DIM_W-1:0]             size_x, size_y, size_z;

  logic signed [VALUE_BITS-1:0] mem [DEPTH];
  logic signed [VALUE_BITS-1:0] rdata;

  logic [DIM_W-1:0]    nx, ny, nz, hx, hy, hz, p6;
  logic [DIM_W-1:0]    x, y, z;
  logic [STRIDE_W-1:0] stride_x;
  logic [ADDR_W-1:0]   pnz, base_x, base_xy, center, nb_addr;
  logic [NB_W-1:0]     nb;
  logic [COUNT_W-1:0]  count;
  logic                nb_valid;
  logic                re, we;
  logic [ADDR_W-1:0]   raddr, waddr;
  logic signed [VALUE_BITS-1:0] wdata;

  function automatic logic near(input logic signed [VALUE_BITS-1:0] a,
                                input logic signed [VALUE_BITS-1:0] b,
                                input logic [TOL_W-1:0] tol);
    logic signed [VALUE_BITS:0] d;
    logic [VALUE_BITS:0]        m;
    begin
      d = (VALUE_BITS+1)'(a) - (VALUE_BITS+1)'(b);
      m = d[VALUE_BITS] ? (VALUE_BITS+1)'(-d) : (VALUE_BITS+1)'(d);
      near = m < (VALUE_BITS+1)'(tol);
    end
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      old_value      <= '0;
      adjacent_value <= '0;
      new_value      <= '0;
      tolerance      <= TOL_W'(66);
      pad_width      <= PAD_W'(1);
      size_x         <= DIM_W'(MAX_DIM);
      size_y         <= DIM_W'(MAX_DIM);
      size_z         <= DIM_W'(MAX_DIM);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_OLD_VALUE: old_value      <= cfg_wdata[VALUE_BITS-1:0];
        CFG_ADJ_VALUE: adjacent_value <= cfg_wdata[VALUE_BITS-1:0];
        CFG_NEW_VALUE: new_value      <= cfg_wdata[VALUE_BITS-1:0];
        CFG_TOLERANCE: tolerance      <= cfg_wdata[TOL_W-1:0];
        CFG_PAD_WIDTH: pad_width      <= cfg_wdata[PAD_W-1:0];
        CFG_SIZE_X:    size_x         <= cfg_wdata[DIM_W-1:0];
        CFG_SIZE_Y:    size_y         <= cfg_wdata[DIM_W-1:0];
        CFG_SIZE_Z:    size_z         <= cfg_wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    nx = (size_x > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : size_x;
    ny = (size_y > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : size_y;
    nz = (size_z > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : size_z;
    p6 = DIM_W'(pad_width);
    hx = nx - p6;
    hy = ny - p6;
    hz = nz - p6;
    sts.box_empty = ({pad_width, 1'b0} >= (PAD_W+1)'(nx)) ||
                    ({pad_width, 1'b0} >= (PAD_W+1)'(ny)) ||
                    ({pad_width, 1'b0} >= (PAD_W+1)'(nz));
    center = base_xy + ADDR_W'(z);
    nb_valid = 1'b0;
    nb_addr  = center;
    case (nb)
      3'd0: begin nb_valid = x > p6;            nb_addr = center - ADDR_W'(stride_x); end
      3'd1: begin nb_valid = (x + 1'b1) < nx;   nb_addr = center + ADDR_W'(stride_x); end
      3'd2: begin nb_valid = y > p6;            nb_addr = center - ADDR_W'(nz); end
      3'd3: begin nb_valid = (y + 1'b1) < ny;   nb_addr = center + ADDR_W'(nz); end
      3'd4: begin nb_valid = z > p6;            nb_addr = center - ADDR_W'(1); end
      3'd5: begin nb_valid = (z + 1'b1) < nz;   nb_addr = center + ADDR_W'(1); end
      default: nb_valid = 1'b0;
    endcase
    sts.nb_valid  = nb_valid;
    sts.nb_last   = (nb == NB_LAST);
    sts.near_old  = near(rdata, old_value, tolerance);
    sts.near_adj  = near(rdata, adjacent_value, tolerance);
    sts.scan_done = ((z + 1'b1) >= hz) && ((y + 1'b1) >= hy) && ((x + 1'b1) >= hx);
    sts.out_free  = !out_valid || out_ready;

    re    = ctl.rd_ext || ctl.ctr_rd || ctl.nb_rd;
    raddr = ctl.rd_ext ? in_index : (ctl.ctr_rd ? center : nb_addr);
    we    = ctl.wr_ext || ctl.wr_new;
    waddr = ctl.wr_ext ? in_index : center;
    wdata = ctl.wr_ext ? in_value : new_value;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // scan position and stride registers
  always_ff @(posedge clk) begin
    if (ctl.init1) begin
      stride_x <= STRIDE_W'(ny) * STRIDE_W'(nz);
      pnz      <= ADDR_W'(p6) * ADDR_W'(nz);
      x        <= p6;
      y        <= p6;
      z        <= p6;
    end
    if (ctl.init2) begin
      base_x <= ADDR_W'(p6) * ADDR_W'(stride_x);
    end
    if (ctl.init3) begin
      base_xy <= base_x + pnz;
    end
    if (ctl.nb_clr) begin
      nb <= '0;
    end else if (ctl.nb_inc) begin
      nb <= nb + 1'b1;
    end
    if (ctl.advance) begin
      if ((z + 1'b1) < hz) begin
        z <= z + 1'b1;
      end else begin
        z <= p6;
        if ((y + 1'b1) < hy) begin
          y       <= y + 1'b1;
          base_xy <= base_xy + ADDR_W'(nz);
        end else begin
          y       <= p6;
          x       <= x + 1'b1;
          base_x  <= base_x + ADDR_W'(stride_x);
          base_xy <= base_x + ADDR_W'(stride_x) + pnz;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.init1) begin
      count <= '0;
    end else if (ctl.wr_new && count != '1) begin
      count <= count + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_read || ctl.load_report) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_read) begin
      out_read_value    <= rdata;
      out_changed_count <= '0;
      out_is_run        <= 1'b0;
    end else if (ctl.load_report) begin
      out_read_value    <= '0;
      out_changed_count <= count;
      out_is_run        <= 1'b1;
    end
  end

endmodule
`default_nettype wire

### rtl/voxel_surface_relabel.sv
// Top level of the voxel surface relabel block.
//
//   channel  direction  handshake    word
//   req      in         valid/ready  command, voxel_index, voxel_value
//   rsp      out        valid/ready  read_value, changed_count, is_run_report
//   cfg      in         cfg_we       cfg_index, cfg_wdata (write only)
//
// A write is done while idle; the next word is taken on the following cycle.
// A read word first reads the memory and then loads the output register; the load
// waits only while an earlier result is still held.
// A run walks the interior box one voxel at a time through the single memory read
// port: setup in INIT1 to INIT3, then per voxel a center read, check and advance;
// a voxel near the old value also reads its valid neighbors and may be rewritten.
// Reset (synchronous, active high) clears the controller, the output valid flag,
// the change count and the configuration registers; the voxel memory is not cleared.
// A stalled response holds its word; new requests are still taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module voxel_surface_relabel (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [2:0]                 cfg_index,
  input  wire logic [vsr_pkg::CFG_W-1:0]  cfg_wdata,
  vsr_req_if.sink                         req,
  vsr_rsp_if.source                       rsp
);
  import vsr_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // The controller sequences reads, writes and the scan; the datapath does the work.
  vsr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_command (req.command),
    .in_ready   (req.ready),
    .sts        (sts),
    .ctl        (ctl)
  );

  vsr_dpath u_dpath (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_index          (req.voxel_index),
    .in_value          (req.voxel_value),
    .out_ready         (rsp.ready),
    .out_valid         (rsp.valid),
    .out_read_value    (rsp.read_value),
    .out_changed_count (rsp.changed_count),
    .out_is_run        (rsp.is_run_report),
    .ctl               (ctl),
    .sts               (sts)
  );

endmodule
`default_nettype wire

### rtl/vsr_checker.sv
// Port level checks of the voxel surface relabel block and their binding.
`timescale 1ns / 1ps
`default_nettype none
module vsr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic [1:0]  req_command,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [31:0] rsp_read_value,
  input wire logic [15:0] rsp_changed_count,
  input wire logic        rsp_is_run
);
  import vsr_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value) &&
      $stable(rsp_changed_count) && $stable(rsp_is_run))
    else $error("response changed while stalled");

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_command == OP_READ |=> !req_ready)
    else $error("request taken during a read");

  a_write_free: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_command == OP_WRITE |=> req_ready)
    else $error("write blocked the next request");

  a_read_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_is_run |-> rsp_changed_count == '0)
    else $error("read data carries a count");

  a_run_value: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_is_run |-> rsp_read_value == '0)
    else $error("run report carries a value");

endmodule

bind voxel_surface_relabel vsr_checker u_vsr_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .req_command       (req.command),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_read_value    (rsp.read_value),
  .rsp_changed_count (rsp.changed_count),
  .rsp_is_run        (rsp.is_run_report)
);
`default_nettype wire
